>>> src/integer_array_list_engine_core_macros.svh
// Assertion helpers for the list engine controller.
`ifndef INTEGER_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define INTEGER_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IALST_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IALST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ialst_pkg.sv
package ialst_pkg;

    // List geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of the requests and results.
    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SORT   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Memory read address selects.
    localparam logic [1:0] RD_J   = 2'd0;
    localparam logic [1:0] RD_JP1 = 2'd1;
    localparam logic [1:0] RD_I   = 2'd2;
    localparam logic [1:0] RD_IDX = 2'd3;

    // Memory write address and data selects.
    localparam logic [1:0] WR_APPEND = 2'd0;
    localparam logic [1:0] WR_SHIFT  = 2'd1;
    localparam logic [1:0] WR_SWAP   = 2'd2;
    localparam logic [1:0] WR_PLACE  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_req;
        logic                clr_count;
        logic                inc_count;
        logic                dec_count;
        logic                j_clear;
        logic                j_inc;
        logic                j_set_ip1;
        logic                i_clear;
        logic                i_inc;
        logic                a_load;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic [1:0]          wr_sel;
        logic                res_wr;
        logic [STATUS_W-1:0] res_status;
        logic                res_pos_en;
        logic                res_data_en;
        logic                out_load;
    } ialst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              j_lt_cnt;
        logic              jp1_lt_cnt;
        logic              ip1_lt_cnt;
        logic              idx_ok;
        logic              eq;
        logic              gt;
    } ialst_sts_t;

endpackage

>>> src/integer_array_list_engine_core.sv
// Integer array list engine.
// Requests arrive on the s_ channel: tuser carries the operation code, tdata the
// value and the read index. Results leave on the m_ channel: tuser carries the
// status, tdata the position, the read data and the entry count afterwards.
// Each request gives exactly one result, in request order.
// Find walks the entries in order until the value is found; delete then moves
// every later entry down by one. Sort is an exchange sort over all entries
// (one memory read port).
// One request is worked on at a time; the next one is accepted as soon as the
// previous result has been loaded into the output register, even if the
// receiver has not yet taken it. If the receiver stalls, the finished result
// waits in the engine and no further request is accepted until it is free.
// Reset empties the list and clears the output valid; the entry memory needs no
// clearing pass, as entries are only read below the count.
module integer_array_list_engine_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // value[31:0], index[37:32], zero pad
    input  logic [ialst_pkg::FUNC_W-1:0]   s_tuser,   // func[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // position[5:0], data[37:6], length[44:38]
    output logic [ialst_pkg::STATUS_W-1:0] m_tuser    // status[1:0]
);

    ialst_pkg::ialst_cmd_t cmd;
    ialst_pkg::ialst_sts_t sts;

    // Operation sequencer.
    ialst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Entry memory, counters and result registers.
    ialst_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

>>> src/ialst_datapath.sv
module ialst_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ialst_pkg::ialst_cmd_t                cmd,
    output ialst_pkg::ialst_sts_t                sts,
    input  logic [39:0]                          s_tdata,  // value[31:0], index[37:32]
    input  logic [ialst_pkg::FUNC_W-1:0]         s_tuser,  // func[2:0]
    output logic [47:0]                          m_tdata,  // position, data, length
    output logic [ialst_pkg::STATUS_W-1:0]       m_tuser   // status[1:0]
);

    // Latched request.
    logic [ialst_pkg::FUNC_W-1:0]   func_reg;
    logic [ialst_pkg::WORD_W-1:0]   value_reg;
    logic [ialst_pkg::IDX_W-1:0]    index_reg;

    // Count and walk indices.
    logic [ialst_pkg::CNT_W-1:0]    count_reg;
    logic [ialst_pkg::CNT_W-1:0]    i_reg;
    logic [ialst_pkg::CNT_W-1:0]    j_reg;
    logic [ialst_pkg::CNT_W-1:0]    i_p1;
    logic [ialst_pkg::CNT_W-1:0]    j_p1;

    // Sort holding word and registered read data.
    logic [ialst_pkg::WORD_W-1:0]   a_reg;
    logic [ialst_pkg::WORD_W-1:0]   rdata_reg;

    // Result fields and the output register.
    logic [ialst_pkg::STATUS_W-1:0] res_status_reg;
    logic [ialst_pkg::POS_W-1:0]    res_pos_reg;
    logic [ialst_pkg::WORD_W-1:0]   res_data_reg;
    logic [47:0]                    out_data_reg;
    logic [ialst_pkg::STATUS_W-1:0] out_user_reg;

    // Memory ports.
    logic [ialst_pkg::WORD_W-1:0]   mem [ialst_pkg::DEPTH];
    logic [ialst_pkg::ADDR_W-1:0]   rd_addr;
    logic [ialst_pkg::ADDR_W-1:0]   wr_addr;
    logic [ialst_pkg::WORD_W-1:0]   wr_data;

    assign i_p1 = i_reg + 1'b1;
    assign j_p1 = j_reg + 1'b1;

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg  <= s_tuser;
            value_reg <= s_tdata[31:0];
            index_reg <= s_tdata[37:32];
        end
    end

    // Entry count and walk indices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_count)
                count_reg <= '0;
            else if (cmd.inc_count)
                count_reg <= count_reg + 1'b1;
            else if (cmd.dec_count)
                count_reg <= count_reg - 1'b1;

            if (cmd.i_clear)
                i_reg <= '0;
            else if (cmd.i_inc)
                i_reg <= i_p1;

            if (cmd.j_clear)
                j_reg <= '0;
            else if (cmd.j_set_ip1)
                j_reg <= i_p1;
            else if (cmd.j_inc)
                j_reg <= j_p1;
        end
    end

    // Address and data selection for the memory.
    always_comb
    begin
        case (cmd.rd_sel)
            ialst_pkg::RD_J:   rd_addr = j_reg[ialst_pkg::ADDR_W-1:0];
            ialst_pkg::RD_JP1: rd_addr = j_p1[ialst_pkg::ADDR_W-1:0];
            ialst_pkg::RD_I:   rd_addr = i_reg[ialst_pkg::ADDR_W-1:0];
            default:           rd_addr = ialst_pkg::ADDR_W'(index_reg);
        endcase
        case (cmd.wr_sel)
            ialst_pkg::WR_APPEND:
            begin
                wr_addr = count_reg[ialst_pkg::ADDR_W-1:0];
                wr_data = value_reg;
            end
            ialst_pkg::WR_SHIFT:
            begin
                wr_addr = j_reg[ialst_pkg::ADDR_W-1:0];
                wr_data = rdata_reg;
            end
            ialst_pkg::WR_SWAP:
            begin
                wr_addr = j_reg[ialst_pkg::ADDR_W-1:0];
                wr_data = a_reg;
            end
            default:
            begin
                wr_addr = i_reg[ialst_pkg::ADDR_W-1:0];
                wr_data = a_reg;
            end
        endcase
    end

    // Entry memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Sort holding word: the running minimum for the current outer position.
    always_ff @(posedge clk)
    begin
        if (cmd.a_load)
            a_reg <= rdata_reg;
    end

    // Result fields, then the output register with the count after the operation.
    always_ff @(posedge clk)
    begin
        if (cmd.res_wr)
        begin
            res_status_reg <= cmd.res_status;
            res_pos_reg    <= cmd.res_pos_en ? ialst_pkg::POS_W'(j_reg) : '0;
            res_data_reg   <= cmd.res_data_en ? rdata_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_user_reg <= res_status_reg;
            out_data_reg <= {3'b000, ialst_pkg::LEN_W'(count_reg), res_data_reg, res_pos_reg};
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    // Status for the controller.
    assign sts.func       = func_reg;
    assign sts.full       = (count_reg >= ialst_pkg::CNT_W'(ialst_pkg::DEPTH));
    assign sts.j_lt_cnt   = (j_reg < count_reg);
    assign sts.jp1_lt_cnt = (j_p1 < count_reg);
    assign sts.ip1_lt_cnt = (i_p1 < count_reg);
    assign sts.idx_ok     = (32'(index_reg) < 32'(count_reg));
    assign sts.eq         = (rdata_reg == value_reg);
    assign sts.gt         = ($signed(a_reg) > $signed(rdata_reg));

endmodule

>>> src/ialst_ctrl.sv
`include "integer_array_list_engine_core_macros.svh"

module ialst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ialst_pkg::ialst_sts_t sts,
    output ialst_pkg::ialst_cmd_t cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_SCAN_RD    = 4'd2;
    localparam logic [3:0] S_SCAN_CMP   = 4'd3;
    localparam logic [3:0] S_SHIFT_RD   = 4'd4;
    localparam logic [3:0] S_SHIFT_WR   = 4'd5;
    localparam logic [3:0] S_SORT_OUTER = 4'd6;
    localparam logic [3:0] S_SORT_LOADA = 4'd7;
    localparam logic [3:0] S_SORT_RD    = 4'd8;
    localparam logic [3:0] S_SORT_CMP   = 4'd9;
    localparam logic [3:0] S_READ_WAIT  = 4'd10;
    localparam logic [3:0] S_DONE       = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    // Sequencer: issues datapath commands for each operation.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.func)
                    ialst_pkg::FN_CLEAR:
                    begin
                        cmd.clr_count  = 1'b1;
                        cmd.res_wr     = 1'b1;
                        cmd.res_status = ialst_pkg::ST_OK;
                        state_next     = S_DONE;
                    end
                    ialst_pkg::FN_APPEND:
                    begin
                        cmd.res_wr = 1'b1;
                        if (sts.full)
                            cmd.res_status = ialst_pkg::ST_FULL;
                        else
                        begin
                            cmd.res_status = ialst_pkg::ST_OK;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_sel     = ialst_pkg::WR_APPEND;
                            cmd.inc_count  = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    ialst_pkg::FN_FIND, ialst_pkg::FN_DELETE:
                    begin
                        cmd.j_clear = 1'b1;
                        state_next  = S_SCAN_RD;
                    end
                    ialst_pkg::FN_SORT:
                    begin
                        cmd.i_clear    = 1'b1;
                        cmd.res_wr     = 1'b1;
                        cmd.res_status = ialst_pkg::ST_OK;
                        state_next     = S_SORT_OUTER;
                    end
                    ialst_pkg::FN_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = ialst_pkg::RD_IDX;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            cmd.res_wr     = 1'b1;
                            cmd.res_status = ialst_pkg::ST_BAD_INDEX;
                            state_next     = S_DONE;
                        end
                    end
                    default:
                    begin
                        cmd.res_wr     = 1'b1;
                        cmd.res_status = ialst_pkg::ST_OK;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (sts.j_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ialst_pkg::RD_J;
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    cmd.res_wr     = 1'b1;
                    cmd.res_status = ialst_pkg::ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.eq)
                begin
                    cmd.res_wr     = 1'b1;
                    cmd.res_status = ialst_pkg::ST_OK;
                    cmd.res_pos_en = 1'b1;
                    state_next     = (sts.func == ialst_pkg::FN_DELETE) ? S_SHIFT_RD : S_DONE;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.jp1_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ialst_pkg::RD_JP1;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ialst_pkg::WR_SHIFT;
                cmd.j_inc  = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_SORT_OUTER:
            begin
                if (sts.ip1_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ialst_pkg::RD_I;
                    state_next = S_SORT_LOADA;
                end
                else
                    state_next = S_DONE;
            end
            S_SORT_LOADA:
            begin
                cmd.a_load    = 1'b1;
                cmd.j_set_ip1 = 1'b1;
                state_next    = S_SORT_RD;
            end
            S_SORT_RD:
            begin
                if (sts.j_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ialst_pkg::RD_J;
                    state_next = S_SORT_CMP;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = ialst_pkg::WR_PLACE;
                    cmd.i_inc  = 1'b1;
                    state_next = S_SORT_OUTER;
                end
            end
            S_SORT_CMP:
            begin
                if (sts.gt)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = ialst_pkg::WR_SWAP;
                    cmd.a_load = 1'b1;
                end
                cmd.j_inc  = 1'b1;
                state_next = S_SORT_RD;
            end
            S_READ_WAIT:
            begin
                cmd.res_wr      = 1'b1;
                cmd.res_status  = ialst_pkg::ST_OK;
                cmd.res_data_en = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb
    begin
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // A result is never loaded over one that is still waiting.
    `IALST_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, (!m_tvalid_reg || m_tready), "result overwritten")
    // An accepted request is decoded in the following cycle.
    `IALST_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, (s_tvalid && s_tready), (state_reg == S_DISPATCH), "request not dispatched")
    // A loaded result is offered in the following cycle.
    `IALST_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, m_tvalid_reg, "loaded result not offered")

endmodule
